[rtl/thfc_pkg.sv]
`default_nettype none

package thfc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TEMP_W = 18;
  localparam int unsigned HUM_W  = 17;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

  localparam int unsigned TEMP_SPAN   = 175000;
  localparam int unsigned HUM_SPAN    = 100000;
  localparam int unsigned TEMP_OFFSET = 45000;

  // Stage load enables shared by both lanes.
  typedef struct packed {
    logic s1;
    logic s2;
  } thfc_en_t;

  // One byte through the CRC-8 register, MSB first.
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] acc;
    acc = v;
    for (int i = 0; i < BYTE_W; i++) begin
      if (acc[BYTE_W-1]) begin
        acc = (acc << 1) ^ CRC_POLY;
      end else begin
        acc = acc << 1;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

[rtl/thfc_lane.sv]
`default_nettype none

module thfc_lane import thfc_pkg::*; #(
  parameter int unsigned Span = 100000
) (
  input  wire logic                           clk_i,
  input  wire thfc_en_t                       en_i,
  input  wire logic [BYTE_W-1:0]              high_i,
  input  wire logic [BYTE_W-1:0]              low_i,
  input  wire logic [BYTE_W-1:0]              check_i,
  output logic                                ok_o,
  output logic [$clog2(Span+1)-1:0]           value_o
);

  localparam int unsigned RawW  = 2 * BYTE_W;
  localparam int unsigned QW    = $clog2(Span + 1);
  localparam int unsigned ProdW = RawW + QW;
  localparam logic [QW-1:0]    SpanC = QW'(Span);
  localparam logic [RawW:0]    FullC = {1'b0, {RawW{1'b1}}};

  // Stage 1: first CRC byte and the scaling product.
  logic [BYTE_W-1:0] acc_q,   acc_d;
  logic [BYTE_W-1:0] low_q;
  logic [BYTE_W-1:0] check_q;
  logic [ProdW-1:0]  prod_q,  prod_d;

  assign acc_d  = crc8_byte(CRC_INIT ^ high_i);
  assign prod_d = ProdW'({high_i, low_i}) * ProdW'(SpanC);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      acc_q   <= acc_d;
      low_q   <= low_i;
      check_q <= check_i;
      prod_q  <= prod_d;
    end
  end

  // Stage 2: second CRC byte and division by 65535.
  // With x = a*2^16 + b we have x = a*65535 + (a + b), so the quotient is a
  // plus the small quotient of a + b, which is folded once more.
  logic [QW-1:0]      hi_part;
  logic [QW:0]        fold1;
  logic [QW-RawW:0]   carry1;
  logic [RawW:0]      fold2;
  logic [QW:0]        quot;
  logic               ok_d;
  logic [QW-1:0]      value_d;

  assign hi_part = prod_q[ProdW-1:RawW];
  assign fold1   = (QW+1)'(hi_part) + (QW+1)'(prod_q[RawW-1:0]);
  assign carry1  = fold1[QW:RawW];
  assign fold2   = (RawW+1)'(carry1) + (RawW+1)'(fold1[RawW-1:0]);
  assign quot    = (QW+1)'(hi_part) + (QW+1)'(carry1) + (QW+1)'(fold2 >= FullC);
  assign value_d = quot[QW-1:0];
  assign ok_d    = (crc8_byte(acc_q ^ low_q) == check_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      ok_o    <= ok_d;
      value_o <= value_d;
    end
  end

endmodule

`default_nettype wire

[rtl/thfc_merge.sv]
`default_nettype none

module thfc_merge import thfc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  output logic                          ready_o,
  input  wire logic                     temp_ok_i,
  input  wire logic [TEMP_W-1:0]        temp_raw_i,
  input  wire logic                     hum_ok_i,
  input  wire logic [HUM_W-1:0]         hum_raw_i,
  output logic                          valid_o,
  input  wire logic                     ready_i,
  output logic                          status_o,
  output logic signed [TEMP_W-1:0]      temp_milli_c_o,
  output logic [HUM_W-1:0]              humidity_milli_rh_o
);

  localparam logic signed [TEMP_W:0] OffsetC = (TEMP_W+1)'(TEMP_OFFSET);

  logic                      valid_q;
  logic                      good;
  logic signed [TEMP_W:0]    temp_wide;
  logic                      status_d;
  logic signed [TEMP_W-1:0]  temp_d;
  logic [HUM_W-1:0]          hum_d;

  assign ready_o   = !valid_q || ready_i;
  assign valid_o   = valid_q;
  assign good      = temp_ok_i && hum_ok_i;
  assign temp_wide = $signed({1'b0, temp_raw_i}) - OffsetC;

  // Either CRC failing zeroes both readings.
  assign status_d = !good;
  assign temp_d   = good ? temp_wide[TEMP_W-1:0] : '0;
  assign hum_d    = good ? hum_raw_i : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      status_o            <= status_d;
      temp_milli_c_o      <= temp_d;
      humidity_milli_rh_o <= hum_d;
    end
  end

endmodule

`default_nettype wire

[rtl/temp_humidity_frame_checker_unit.sv]
// A beat accepted at the input passes the stage 1, stage 2 and merge registers in turn.
// Throughput: one beat per cycle; each of the three stages holds its own beat,
// so a stalled output only stops the stages behind it once they fill.
// The temperature and humidity lanes run in lockstep and the merge stage
// registers the combined result.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data is not reset.
`default_nettype none

module temp_humidity_frame_checker_unit import thfc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [BYTE_W-1:0]        temp_high_byte_i,
  input  wire logic [BYTE_W-1:0]        temp_low_byte_i,
  input  wire logic [BYTE_W-1:0]        temp_check_byte_i,
  input  wire logic [BYTE_W-1:0]        hum_high_byte_i,
  input  wire logic [BYTE_W-1:0]        hum_low_byte_i,
  input  wire logic [BYTE_W-1:0]        hum_check_byte_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          status_o,
  output logic signed [TEMP_W-1:0]      temp_milli_c_o,
  output logic [HUM_W-1:0]              humidity_milli_rh_o
);

  logic              v1_q;
  logic              v2_q;
  logic              merge_ready;
  thfc_en_t          en;
  logic              temp_ok;
  logic              hum_ok;
  logic [TEMP_W-1:0] temp_raw;
  logic [HUM_W-1:0]  hum_raw;

  assign en.s2      = !v2_q || merge_ready;
  assign en.s1      = !v1_q || en.s2;
  assign in_ready_o = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en.s1) begin
        v1_q <= in_valid_i;
      end
      if (en.s2) begin
        v2_q <= v1_q;
      end
    end
  end

  thfc_lane #(
    .Span (TEMP_SPAN)
  ) u_temp_lane (
    .clk_i   (clk_i),
    .en_i    (en),
    .high_i  (temp_high_byte_i),
    .low_i   (temp_low_byte_i),
    .check_i (temp_check_byte_i),
    .ok_o    (temp_ok),
    .value_o (temp_raw)
  );

  thfc_lane #(
    .Span (HUM_SPAN)
  ) u_hum_lane (
    .clk_i   (clk_i),
    .en_i    (en),
    .high_i  (hum_high_byte_i),
    .low_i   (hum_low_byte_i),
    .check_i (hum_check_byte_i),
    .ok_o    (hum_ok),
    .value_o (hum_raw)
  );

  thfc_merge u_merge (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (v2_q),
    .ready_o             (merge_ready),
    .temp_ok_i           (temp_ok),
    .temp_raw_i          (temp_raw),
    .hum_ok_i            (hum_ok),
    .hum_raw_i           (hum_raw),
    .valid_o             (out_valid_o),
    .ready_i             (out_ready_i),
    .status_o            (status_o),
    .temp_milli_c_o      (temp_milli_c_o),
    .humidity_milli_rh_o (humidity_milli_rh_o)
  );

endmodule

`default_nettype wire

[tb/thfc_reading_monitor.sv]
`timescale 1ns / 100ps

package thfc_reading_tb_pkg;
  import thfc_pkg::*;

  localparam int unsigned RAW_FULL_SCALE = 65535;

  // One converted sensor reading as it leaves the block.
  typedef struct packed {
    logic              bad_crc;
    logic [TEMP_W-1:0] temp_mc;
    logic [HUM_W-1:0]  hum_mrh;
  } reading_t;

  // CRC-8, polynomial 0x31, seeded with 0xFF, shifted MSB first over two bytes.
  function automatic logic [BYTE_W-1:0] sensor_crc(input logic [BYTE_W-1:0] first,
                                                    input logic [BYTE_W-1:0] second);
    logic [BYTE_W-1:0] acc;
    logic [2*BYTE_W-1:0] stream;
    stream = {first, second};
    acc = CRC_INIT;
    for (int k = 2*BYTE_W-1; k >= 0; k--) begin
      if (acc[BYTE_W-1] ^ stream[k]) begin
        acc = {acc[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[BYTE_W-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

  function automatic reading_t convert_frame(input logic [BYTE_W-1:0] th,
                                             input logic [BYTE_W-1:0] tl,
                                             input logic [BYTE_W-1:0] tc,
                                             input logic [BYTE_W-1:0] hh,
                                             input logic [BYTE_W-1:0] hl,
                                             input logic [BYTE_W-1:0] hc);
    reading_t r;
    longint unsigned scaled_t;
    longint unsigned scaled_h;
    longint degrees;
    r = '0;
    // A bad check byte on either word zeroes both values.
    if (sensor_crc(th, tl) != tc || sensor_crc(hh, hl) != hc) begin
      r.bad_crc = 1'b1;
      return r;
    end
    scaled_t = (64'(TEMP_SPAN) * 64'({th, tl})) / 64'(RAW_FULL_SCALE);
    scaled_h = (64'(HUM_SPAN) * 64'({hh, hl})) / 64'(RAW_FULL_SCALE);
    if (scaled_h > 64'(HUM_SPAN)) begin
      scaled_h = 64'(HUM_SPAN);
    end
    degrees = longint'(scaled_t) - longint'(TEMP_OFFSET);
    r.temp_mc = degrees[TEMP_W-1:0];
    r.hum_mrh = scaled_h[HUM_W-1:0];
    return r;
  endfunction

endpackage

module thfc_reading_monitor import thfc_pkg::*; import thfc_reading_tb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [BYTE_W-1:0] temp_high_byte_i,
  input  logic [BYTE_W-1:0] temp_low_byte_i,
  input  logic [BYTE_W-1:0] temp_check_byte_i,
  input  logic [BYTE_W-1:0] hum_high_byte_i,
  input  logic [BYTE_W-1:0] hum_low_byte_i,
  input  logic [BYTE_W-1:0] hum_check_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              status_i,
  input  logic [TEMP_W-1:0] temp_milli_c_i,
  input  logic [HUM_W-1:0]  humidity_milli_rh_i,
  output int                pending_o,
  output int                fail_count_o
);

  reading_t readings_due[$];
  reading_t seen;
  reading_t want;
  int failures = 0;

  initial begin
    pending_o = 0;
    fail_count_o = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        readings_due.push_back(convert_frame(temp_high_byte_i, temp_low_byte_i,
                                             temp_check_byte_i, hum_high_byte_i,
                                             hum_low_byte_i, hum_check_byte_i));
      end
      if (out_valid_i && out_ready_i) begin
        seen = '{bad_crc: status_i, temp_mc: temp_milli_c_i, hum_mrh: humidity_milli_rh_i};
        if (readings_due.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("unexpected result beat: status %0b temp %0d hum %0d",
                     seen.bad_crc, $signed(seen.temp_mc), seen.hum_mrh);
          end
        end else begin
          want = readings_due.pop_front();
          if (seen != want) begin
            failures++;
            if (failures <= 10) begin
              $display("result mismatch: status %0b/%0b temp %0d/%0d hum %0d/%0d (exp/got)",
                       want.bad_crc, seen.bad_crc,
                       $signed(want.temp_mc), $signed(seen.temp_mc),
                       want.hum_mrh, seen.hum_mrh);
            end
          end
        end
      end
      pending_o <= readings_due.size();
      fail_count_o <= failures;
    end
  end

endmodule

[tb/temp_humidity_frame_checker_unit_test.sv]
`timescale 1ns / 100ps

module temp_humidity_frame_checker_unit_test import thfc_pkg::*; import thfc_reading_tb_pkg::*;;

  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_FRAMES = 1000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic [BYTE_W-1:0] temp_high_byte_i = '0;
  logic [BYTE_W-1:0] temp_low_byte_i = '0;
  logic [BYTE_W-1:0] temp_check_byte_i = '0;
  logic [BYTE_W-1:0] hum_high_byte_i = '0;
  logic [BYTE_W-1:0] hum_low_byte_i = '0;
  logic [BYTE_W-1:0] hum_check_byte_i = '0;
  logic in_ready_o;
  logic out_valid_o;
  logic status_o;
  logic signed [TEMP_W-1:0] temp_milli_c_o;
  logic [HUM_W-1:0] humidity_milli_rh_o;
  int pending_readings;
  int fail_count;

  // Shared by both sides: while set, neither sender nor receiver idles.
  bit calm = 1'b0;
  int hold_requests = 0;
  int quiet_cycles = 0;

  temp_humidity_frame_checker_unit u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .temp_high_byte_i,
    .temp_low_byte_i,
    .temp_check_byte_i,
    .hum_high_byte_i,
    .hum_low_byte_i,
    .hum_check_byte_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .temp_milli_c_o,
    .humidity_milli_rh_o
  );

  thfc_reading_monitor u_monitor (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i          (in_ready_o),
    .temp_high_byte_i,
    .temp_low_byte_i,
    .temp_check_byte_i,
    .hum_high_byte_i,
    .hum_low_byte_i,
    .hum_check_byte_i,
    .out_valid_i         (out_valid_o),
    .out_ready_i,
    .status_i            (status_o),
    .temp_milli_c_i      (temp_milli_c_o),
    .humidity_milli_rh_i (humidity_milli_rh_o),
    .pending_o           (pending_readings),
    .fail_count_o        (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Holds the frame until the beat is taken, then sometimes leaves a gap.
  task automatic offer_frame(input logic [BYTE_W-1:0] th, input logic [BYTE_W-1:0] tl,
                             input logic [BYTE_W-1:0] tc, input logic [BYTE_W-1:0] hh,
                             input logic [BYTE_W-1:0] hl, input logic [BYTE_W-1:0] hc);
    in_valid_i <= 1'b1;
    temp_high_byte_i <= th;
    temp_low_byte_i <= tl;
    temp_check_byte_i <= tc;
    hum_high_byte_i <= hh;
    hum_low_byte_i <= hl;
    hum_check_byte_i <= hc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic offer_good(input logic [15:0] raw_t, input logic [15:0] raw_h);
    offer_frame(raw_t[15:8], raw_t[7:0], sensor_crc(raw_t[15:8], raw_t[7:0]),
                raw_h[15:8], raw_h[7:0], sensor_crc(raw_h[15:8], raw_h[7:0]));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readings != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(65535, 65500));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] raw_t;
    logic [15:0] raw_h;
    logic [BYTE_W-1:0] tc;
    logic [BYTE_W-1:0] hc;
    int pick;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Range ends and midpoints of both words with good check bytes.
    offer_good(16'h0000, 16'h0000);
    offer_good(16'hFFFF, 16'hFFFF);
    offer_good(16'h0000, 16'hFFFF);
    offer_good(16'hFFFF, 16'h0000);
    offer_good(16'h8000, 16'h7FFF);
    offer_good(16'h0001, 16'hFFFE);
    offer_good(16'h6666, 16'h1234);
    offer_good(16'h4A3B, 16'hA5C3);
    // Bad temperature check byte: humidity word is good but must be ignored.
    offer_frame(8'hFF, 8'hFF, sensor_crc(8'hFF, 8'hFF) ^ 8'h01,
                8'h80, 8'h00, sensor_crc(8'h80, 8'h00));
    // Bad humidity check byte behind a good temperature word.
    offer_frame(8'h66, 8'h66, sensor_crc(8'h66, 8'h66),
                8'hFF, 8'hFF, sensor_crc(8'hFF, 8'hFF) ^ 8'h80);
    // Both check bytes wrong.
    offer_frame(8'h12, 8'h34, sensor_crc(8'h12, 8'h34) ^ 8'hFF,
                8'h56, 8'h78, sensor_crc(8'h56, 8'h78) ^ 8'h5A);
    offer_frame('0, '0, '0, '0, '0, '0);
    offer_frame('1, '1, '1, '1, '1, '1);
    drain_results();

    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      calm = (n >= 300 && n < 450);
      if (n == 600) begin
        hold_requests++;
      end
      if (n == 800) begin
        drain_results();
      end
      raw_t = pick_raw();
      raw_h = pick_raw();
      tc = sensor_crc(raw_t[15:8], raw_t[7:0]);
      hc = sensor_crc(raw_h[15:8], raw_h[7:0]);
      pick = $urandom_range(99);
      if (pick < 75) begin
        // well-formed frame
      end else if (pick < 85) begin
        tc = tc ^ 8'($urandom_range(255, 1));
      end else if (pick < 95) begin
        hc = hc ^ 8'($urandom_range(255, 1));
      end else begin
        tc = 8'($urandom);
        hc = 8'($urandom);
      end
      offer_frame(raw_t[15:8], raw_t[7:0], tc, raw_h[15:8], raw_h[7:0], hc);
    end
    calm = 1'b0;

    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
